### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/srr_pkg.sv
package srr_pkg;

    // sequence space and receive buffer slots
    localparam int MAX_SEQ_NUM  = 7;
    localparam int WINDOW_SLOTS = 4;
    localparam int RESULT_LIMIT = 5;

    localparam int SEQ_W  = 3;
    localparam int WIN_W  = 3;
    localparam int KIND_W = 3;
    localparam int MODE_W = 2;
    localparam int CNT_W  = 3;
    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    // event codes on the input
    localparam logic [MODE_W-1:0] M_GOOD = 2'd0;
    localparam logic [MODE_W-1:0] M_CRC  = 2'd1;
    localparam logic [MODE_W-1:0] M_TICK = 2'd2;
    localparam logic [MODE_W-1:0] M_ACKT = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] K_ACK     = 3'd0;
    localparam logic [KIND_W-1:0] K_NAK     = 3'd1;
    localparam logic [KIND_W-1:0] K_DELIVER = 3'd2;
    localparam logic [KIND_W-1:0] K_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] K_STORE   = 3'd4;
    localparam logic [KIND_W-1:0] K_NONE    = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [WIN_W-1:0]  tokens;
        logic              last;
    } t_result;

    // request to the shared sequence unit
    typedef struct packed {
        logic [SEQ_W-1:0] operand;
        logic [SEQ_W-1:0] lo;
        logic [SEQ_W-1:0] hi;
    } t_alu_req;

    typedef struct packed {
        logic [SEQ_W-1:0] inc;
        logic [SEQ_W-1:0] dec;
        logic             in_win;
    } t_alu_rsp;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (s >= SEQ_W'(MAX_SEQ_NUM)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] s);
        return SLOT_W'(s % WINDOW_SLOTS);
    endfunction

    // out-of-range window sizes pinned to the legal span
    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] w;
        w = v;
        if (v == '0) w = WIN_W'(1);
        else if (v > WIN_W'(WINDOW_SLOTS)) w = WIN_W'(WINDOW_SLOTS);
        return w;
    endfunction

endpackage

### rtl/srr_seq_alu.sv
// shared sequence-number unit: increment, decrement and window test
module srr_seq_alu (
    input  srr_pkg::t_alu_req i_req,
    output srr_pkg::t_alu_rsp o_rsp
);
    import srr_pkg::*;

    logic lo_le_s;
    logic s_lt_hi;
    logic wrap;

    // modular window membership over [lo, hi)
    assign lo_le_s = (i_req.lo <= i_req.operand);
    assign s_lt_hi = (i_req.operand < i_req.hi);
    assign wrap    = (i_req.hi < i_req.lo);

    assign o_rsp.inc    = seq_inc(i_req.operand);
    assign o_rsp.dec    = (i_req.operand == '0) ? SEQ_W'(MAX_SEQ_NUM)
                                                : i_req.operand - 1'b1;
    assign o_rsp.in_win = (i_req.operand <= SEQ_W'(MAX_SEQ_NUM)) &&
                          ((lo_le_s && s_lt_hi) || (wrap && lo_le_s) ||
                           (s_lt_hi && wrap));

endmodule

### rtl/srr_out_stage.sv
// one-deep result register between the sequencer and the output channel
module srr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  srr_pkg::t_result i_res,
    output logic             o_free,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [2:0] seq_out, [5:3] tokens_left, rest zero
    output logic [2:0]       m_axis_tuser,  // [2:0] kind
    output logic             m_axis_tlast
);
    import srr_pkg::*;

    logic    r_valid;
    t_result r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_res.tokens, r_res.seq};
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.last;

endmodule

### rtl/selective_repeat_receiver_unit.sv
// Selective-repeat receiver with a token-bucket limit on in-order delivery.
// Input channel s_axis: one beat per event; tuser is the event (good frame,
// checksum error, rate tick, ack timer expiry), tdata holds the frame number.
// Output channel m_axis: one beat per result (ack, nak, delivered, discarded,
// stored or nothing) with the token count after it; tlast marks the final
// beat caused by an event. Every event gives between one and five beats.
// Config: i_cfg_we with i_cfg_wdata sets the window size and restarts the
// receiver; write only while the block is idle.
// Timing: an event is taken when s_axis_tready is high (sequencer idle). The
// first result is loaded into the output register by the head step (by the
// store step for a good frame that sends no nak), then one beat per cycle
// while the output register is free. An event passes through the sequencer
// steps idle and head (tick, checksum error, timer), idle, head and store (good
// frame, no delivery), or these and one drain step per delivery (up to 4): the
// drain walks the arrival bitmap one slot a cycle via the shared sequence unit.
// Reset (synchronous, active low) sets window size 4, clears the bitmap and
// fills the token bucket. When m_axis_tready is low the sequencer holds its
// step until the output register frees, so nothing is lost or repeated.
`include "assert_macros.svh"

module selective_repeat_receiver_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [srr_pkg::WIN_W-1:0] i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [2:0] seq_num, rest unused
    input  logic [1:0]             s_axis_tuser,  // [1:0] mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,  // [2:0] seq_out, [5:3] tokens_left, rest zero
    output logic [2:0]             m_axis_tuser,  // [2:0] kind
    output logic                   m_axis_tlast
);
    import srr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HEAD  = 2'd1;
    localparam logic [1:0] ST_STORE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [MODE_W-1:0]       r_mode, n_mode;
    logic [SEQ_W-1:0]        r_seq, n_seq;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [WIN_W-1:0]        r_win, n_win;
    logic [SEQ_W-1:0]        r_exp, n_exp;
    logic [SEQ_W-1:0]        r_top, n_top;
    logic [WINDOW_SLOTS-1:0] r_map, n_map;
    logic [WIN_W-1:0]        r_tokens, n_tokens;
    logic                    r_nak_ok, n_nak_ok;
    logic                    r_ack_armed, n_ack_armed;

    logic                    s_accept;
    logic                    emit_ok;
    logic                    emit;
    logic                    out_free;
    t_result                 res;
    t_alu_req                alu_req;
    t_alu_rsp                alu_rsp;
    logic [WIN_W-1:0]        cfg_win;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign cfg_win       = clamp_win(i_cfg_wdata);

    // operand select for the shared sequence unit
    always_comb begin
        alu_req.lo      = r_exp;
        alu_req.hi      = r_top;
        alu_req.operand = (r_state == ST_STORE) ? r_seq : r_exp;
    end

    srr_seq_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // sequencer
    always_comb begin
        logic [WINDOW_SLOTS-1:0] map_set;
        logic [WINDOW_SLOTS-1:0] map_clr;
        logic [WIN_W-1:0]        tok_dec;
        logic [CNT_W-1:0]        cnt_inc;
        logic                    more;

        n_state     = r_state;
        n_mode      = r_mode;
        n_seq       = r_seq;
        n_count     = r_count;
        n_win       = r_win;
        n_exp       = r_exp;
        n_top       = r_top;
        n_map       = r_map;
        n_tokens    = r_tokens;
        n_nak_ok    = r_nak_ok;
        n_ack_armed = r_ack_armed;
        emit        = 1'b0;
        res         = '{kind: K_NONE, seq: '0, tokens: r_tokens, last: 1'b1};
        map_set     = r_map;
        map_clr     = r_map;
        tok_dec     = r_tokens - 1'b1;
        cnt_inc     = r_count + 1'b1;
        more        = 1'b0;
        emit_ok     = out_free;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_mode  = s_axis_tuser;
                    n_seq   = s_axis_tdata[SEQ_W-1:0];
                    n_count = '0;
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (emit_ok) begin
                    case (r_mode)
                        M_GOOD: begin
                            if ((r_seq != r_exp) && r_nak_ok) begin
                                n_nak_ok    = 1'b0;
                                n_ack_armed = 1'b0;
                                emit        = 1'b1;
                                res.kind    = K_NAK;
                                res.seq     = r_exp;
                                res.last    = 1'b0;
                                n_count     = cnt_inc;
                            end else begin
                                n_ack_armed = 1'b1;
                            end
                            n_state = ST_STORE;
                        end
                        M_CRC: begin
                            emit = 1'b1;
                            if (r_nak_ok) begin
                                n_nak_ok    = 1'b0;
                                n_ack_armed = 1'b0;
                                res.kind    = K_NAK;
                                res.seq     = r_exp;
                            end
                            n_state = ST_IDLE;
                        end
                        M_TICK: begin
                            emit = 1'b1;
                            if (r_tokens < r_win) begin
                                n_tokens   = r_tokens + 1'b1;
                                res.tokens = r_tokens + 1'b1;
                            end
                            n_state = ST_IDLE;
                        end
                        M_ACKT: begin
                            emit = 1'b1;
                            if (r_ack_armed) begin
                                n_ack_armed = 1'b0;
                                res.kind    = K_ACK;
                                res.seq     = alu_rsp.dec;
                            end
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_STORE: begin
                if (emit_ok) begin
                    emit    = 1'b1;
                    n_count = cnt_inc;
                    res.seq = r_seq;
                    if (alu_rsp.in_win && !r_map[slot_of(r_seq)] && (r_tokens != '0)) begin
                        map_set[slot_of(r_seq)] = 1'b1;
                        n_map    = map_set;
                        more     = map_set[slot_of(r_exp)] &&
                                   (cnt_inc < CNT_W'(RESULT_LIMIT));
                        res.kind = K_STORE;
                        res.last = !more;
                        n_state  = more ? ST_DRAIN : ST_IDLE;
                    end else begin
                        res.kind = K_DISCARD;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                if (emit_ok) begin
                    map_clr[slot_of(r_exp)] = 1'b0;
                    more        = map_clr[slot_of(alu_rsp.inc)] && (tok_dec != '0) &&
                                  (cnt_inc < CNT_W'(RESULT_LIMIT));
                    n_map       = map_clr;
                    n_exp       = alu_rsp.inc;
                    n_top       = seq_inc(r_top);
                    n_nak_ok    = 1'b1;
                    n_ack_armed = 1'b1;
                    n_tokens    = tok_dec;
                    n_count     = cnt_inc;
                    emit        = 1'b1;
                    res.kind    = K_DELIVER;
                    res.seq     = r_exp;
                    res.tokens  = tok_dec;
                    res.last    = !more;
                    n_state     = more ? ST_DRAIN : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // window size write restarts the receiver
        if (i_cfg_we) begin
            n_win       = cfg_win;
            n_exp       = '0;
            n_top       = SEQ_W'(cfg_win);
            n_map       = '0;
            n_tokens    = cfg_win;
            n_nak_ok    = 1'b1;
            n_ack_armed = 1'b0;
        end
    end

    // control and receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_win       <= WIN_W'(WINDOW_SLOTS);
            r_exp       <= '0;
            r_top       <= SEQ_W'(WINDOW_SLOTS % (MAX_SEQ_NUM + 1));
            r_map       <= '0;
            r_tokens    <= WIN_W'(WINDOW_SLOTS);
            r_nak_ok    <= 1'b1;
            r_ack_armed <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_win       <= n_win;
            r_exp       <= n_exp;
            r_top       <= n_top;
            r_map       <= n_map;
            r_tokens    <= n_tokens;
            r_nak_ok    <= n_nak_ok;
            r_ack_armed <= n_ack_armed;
        end
    end

    // captured event
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_seq  <= n_seq;
    end

    srr_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (emit),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // checks on the sequencer
    `ASSERT_IMPL(a_tokens_cap, i_clk, i_rst_n, 1'b1, r_tokens <= r_win)
    `ASSERT_IMPL(a_drain_slot, i_clk, i_rst_n, r_state == ST_DRAIN,
                 r_map[slot_of(r_exp)] && (r_tokens != '0))
    `ASSERT_IMPL(a_result_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(RESULT_LIMIT))
    `ASSERT_NEXT(a_accept_head, i_clk, i_rst_n, s_accept, r_state == ST_HEAD)

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import srr_pkg::*;

    localparam int SEQ_MOD        = MAX_SEQ_NUM + 1;
    localparam int HOLD_CYCLES    = 160;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_EVENTS   = 28;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEQ_W-1:0]  seq;
    } t_event;

    // block ports
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [WIN_W-1:0] i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;  // [2:0] seq_num, rest zero
    logic [1:0]       s_axis_tuser = '0;  // [1:0] mode
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;       // [2:0] seq_out, [5:3] tokens_left, rest zero
    logic [2:0]       m_axis_tuser;       // [2:0] kind
    logic             m_axis_tlast;

    // predicted receiver state
    logic [WIN_W-1:0] win_reg;
    logic [SEQ_W-1:0] rx_next;
    logic [SEQ_W-1:0] rx_top;
    logic             slot_full [WINDOW_SLOTS];
    logic [CNT_W-1:0] credit;
    logic             nak_ok;
    logic             ack_pending;

    // per-event report collection
    t_result burst [RESULT_LIMIT];
    int      burst_len;

    t_result pending_reports [$];
    t_event  event_q [$];
    t_event  next_ev;
    t_result want;

    int   fail_count = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   sink_wait = 0;
    int   sink_next;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;
    logic quiet = 1'b0;

    logic [WIN_W-1:0] phase_sizes [8] = '{3'd1, 3'd7, 3'd0, 3'd2, 3'd5, 3'd3, 3'd6, 3'd4};

    selective_repeat_receiver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // effective window width, out-of-range sizes pinned
    function automatic int window_span();
        int w;
        w = int'(win_reg);
        if (w < 1) return 1;
        if (w > WINDOW_SLOTS) return WINDOW_SLOTS;
        return w;
    endfunction

    function automatic logic [SEQ_W-1:0] seq_after(input logic [SEQ_W-1:0] s);
        return SEQ_W'((int'(s) + 1) % SEQ_MOD);
    endfunction

    // distance of a frame number ahead of the expected one
    function automatic int ahead_of_next(input logic [SEQ_W-1:0] s);
        return (int'(s) - int'(rx_next) + SEQ_MOD) % SEQ_MOD;
    endfunction

    function automatic void restart_receiver();
        int w;
        w = window_span();
        rx_next = '0;
        rx_top = SEQ_W'(w % SEQ_MOD);
        foreach (slot_full[i]) slot_full[i] = 1'b0;
        credit = CNT_W'(w);
        nak_ok = 1'b1;
        ack_pending = 1'b0;
    endfunction

    function automatic void note(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq);
        burst[burst_len] = '{kind: kind, seq: seq, tokens: credit, last: 1'b0};
        burst_len++;
    endfunction

    // works out the reports one accepted event causes and queues them
    function automatic void predict_reports(input logic [MODE_W-1:0] mode,
                                            input logic [SEQ_W-1:0] seq);
        int               slot;
        logic [SEQ_W-1:0] done;
        burst_len = 0;
        slot = int'(seq) % WINDOW_SLOTS;
        case (mode)
            M_GOOD: begin
                if (seq != rx_next && nak_ok) begin
                    nak_ok = 1'b0;
                    ack_pending = 1'b0;
                    note(K_NAK, rx_next);
                end else begin
                    ack_pending = 1'b1;
                end
                if (ahead_of_next(seq) < ahead_of_next(rx_top) && !slot_full[slot]
                    && credit != 0) begin
                    slot_full[slot] = 1'b1;
                    note(K_STORE, seq);
                    // in-order drain while the expected slot is filled
                    while (burst_len < RESULT_LIMIT && slot_full[int'(rx_next) % WINDOW_SLOTS]
                           && credit != 0) begin
                        done = rx_next;
                        nak_ok = 1'b1;
                        slot_full[int'(rx_next) % WINDOW_SLOTS] = 1'b0;
                        rx_next = seq_after(rx_next);
                        rx_top = seq_after(rx_top);
                        ack_pending = 1'b1;
                        credit = credit - 1'b1;
                        note(K_DELIVER, done);
                    end
                end else begin
                    note(K_DISCARD, seq);
                end
            end
            M_CRC: begin
                if (nak_ok) begin
                    nak_ok = 1'b0;
                    ack_pending = 1'b0;
                    note(K_NAK, rx_next);
                end
            end
            M_TICK: begin
                if (int'(credit) < window_span()) credit = credit + 1'b1;
            end
            M_ACKT: begin
                if (ack_pending) begin
                    ack_pending = 1'b0;
                    note(K_ACK, SEQ_W'((int'(rx_next) + MAX_SEQ_NUM) % SEQ_MOD));
                end
            end
        endcase
        if (burst_len == 0) note(K_NONE, '0);
        burst[burst_len-1].last = 1'b1;
        for (int i = 0; i < burst_len; i++) pending_reports.push_back(burst[i]);
    endfunction

    function automatic int draw_gap();
        if (quiet) return 0;
        return int'($urandom_range(0, 12));
    endfunction

    function automatic void queue_event(input logic [MODE_W-1:0] mode,
                                        input logic [SEQ_W-1:0] seq);
        event_q.push_back('{mode: mode, seq: seq});
    endfunction

    // mostly frames at or just ahead of the expected number, plus ticks and noise
    function automatic t_event random_event();
        t_event ev;
        int     pick;
        pick = int'($urandom_range(0, 99));
        ev.seq = SEQ_W'($urandom_range(0, MAX_SEQ_NUM));
        if (pick < 20) begin
            ev.mode = M_GOOD;
            ev.seq = rx_next;
        end else if (pick < 55) begin
            ev.mode = M_GOOD;
            ev.seq = SEQ_W'((int'(rx_next) + int'($urandom_range(1, window_span()))) % SEQ_MOD);
        end else if (pick < 62) begin
            ev.mode = M_GOOD;
        end else if (pick < 80) begin
            ev.mode = M_TICK;
        end else if (pick < 90) begin
            ev.mode = M_CRC;
        end else begin
            ev.mode = M_ACKT;
        end
        return ev;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk);
        while (event_q.size() != 0 || s_axis_tvalid || pending_reports.size() != 0
               || !s_axis_tready || m_axis_tvalid);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        wait_drained();
        i_cfg_wdata <= value;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_reg = value;
        restart_receiver();
    endtask

    // event driver, one beat per queued event
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_reports(s_axis_tuser, s_axis_tdata[SEQ_W-1:0]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (event_q.size() != 0) begin
                    next_ev = event_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_ev.mode;
                    s_axis_tdata <= {{(8-SEQ_W){1'b0}}, next_ev.seq};
                    send_gap <= draw_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, fired once
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // report monitor and random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait <= 0;
        end else begin
            sink_next = (sink_wait != 0) ? sink_wait - 1 : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual kind %0d seq %0d",
                             $time, m_axis_tuser, m_axis_tdata[2:0]);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("kind", int'(want.kind), int'(m_axis_tuser));
                    check_field("seq_out", int'(want.seq), int'(m_axis_tdata[2:0]));
                    check_field("tokens_left", int'(want.tokens), int'(m_axis_tdata[5:3]));
                    check_field("last", int'(want.last), int'(m_axis_tlast));
                end
                sink_next = draw_gap();
            end
            sink_wait <= sink_next;
            m_axis_tready <= (sink_next == 0) && (hold_left == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        win_reg = WIN_W'(WINDOW_SLOTS);
        restart_receiver();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle timer, tick at full bucket, nak once then suppressed
        queue_event(M_ACKT, 3'd0);
        queue_event(M_TICK, 3'd5);
        queue_event(M_CRC, 3'd0);
        queue_event(M_CRC, 3'd0);
        // out-of-window frame, then ack across the wrap
        queue_event(M_GOOD, 3'd7);
        queue_event(M_ACKT, 3'd2);
        // out-of-order frames, then a full drain that empties the bucket
        queue_event(M_GOOD, 3'd1);
        queue_event(M_GOOD, 3'd2);
        queue_event(M_GOOD, 3'd3);
        queue_event(M_GOOD, 3'd0);
        queue_event(M_GOOD, 3'd4);
        queue_event(M_TICK, 3'd0);
        // frames left stored once tokens run out
        queue_event(M_GOOD, 3'd5);
        queue_event(M_GOOD, 3'd6);
        queue_event(M_GOOD, 3'd7);
        queue_event(M_GOOD, 3'd4);
        repeat (4) queue_event(M_TICK, 3'd7);
        // nak plus store plus drain hits the per-event limit
        queue_event(M_GOOD, 3'd0);
        queue_event(M_ACKT, 3'd0);
        // duplicate of a stored frame
        queue_event(M_GOOD, 3'd0);
        queue_event(M_GOOD, 3'd1);
        queue_event(M_CRC, 3'd6);

        // random phases over every window setting
        for (int p = 0; p < 8; p++) begin
            write_window(phase_sizes[p]);
            quiet <= (p % 3 == 2);
            if (p == 2) hold_req <= 1'b1;
            for (int k = 0; k < PHASE_EVENTS; k++) begin
                while (event_q.size() >= 2) @(posedge i_clk);
                event_q.push_back(random_event());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
